// File: rtl/rmrt_pkg.sv
// Package for the retransmission timer table: types, codes and sizes.
`default_nettype none
package rmrt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdTick   = 2'd1,
    CmdAck    = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EvInserted = 3'd0,
    EvFull     = 3'd1,
    EvDup      = 3'd2,
    EvRemoved  = 3'd3,
    EvNotFound = 3'd4,
    EvResend   = 3'd5,
    EvExceeded = 3'd6,
    EvTickDone = 3'd7
  } event_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] msg_id;
    logic [15:0] timeout_ms;
    logic [7:0]  max_resends;
    logic [15:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] msg_id_res;
    logic [4:0]  entry_count;
    logic [4:0]  exceeded_count;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StShiftUp,
    StShiftDown,
    StTick,
    StDone
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture input word, clear index
    logic idx_inc;   // step index up
    logic idx_dec;   // step index down
    logic set_idx_count; // index = held count
    logic shift_up;  // slot[idx] = slot[idx-1]
    logic place;     // write new entry at idx, count up
    logic shift_down; // slot[idx] = slot[idx+1]
    logic drop_over; // entry at idx leaves: fix exceeded count
    logic remove;    // count down
    logic tick_step; // update entry at idx
    logic emit;      // emit a result this cycle
    logic [2:0] ev;
    logic use_entry_id; // report stored id rather than input id
    logic is_last;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    cmd_e command;
    logic full;
    logic idx_at_end;   // idx >= held count
    logic id_match;     // entry[idx] id equals input id
    logic prev_greater; // idx>0 and entry[idx-1] id > input id
    logic idx_last;     // idx+1 >= held count
    logic expire;       // entry at idx expires on this tick
    logic will_exceed;  // and has no resends left, not yet exceeded
    logic resend;       // and has resends left
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/rmrt_datapath.sv
// Datapath of the retransmission timer table: entry store, index and counts.
`default_nettype none
module rmrt_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rmrt_pkg::in_word_t in_i,
  input  wire rmrt_pkg::ctl_t    ctl_i,
  output rmrt_pkg::stat_t        stat_o,
  output rmrt_pkg::out_word_t    out_o,
  output logic                   strobe_o
);
  localparam int unsigned D = rmrt_pkg::TableDepth;
  localparam int unsigned IW = rmrt_pkg::IdxW;
  localparam int unsigned CW = rmrt_pkg::CntW;

  logic [31:0] id_q [D];
  logic [15:0] el_q [D];
  logic [15:0] to_q [D];
  logic [7:0]  lim_q [D];
  logic [7:0]  rs_q [D];
  logic        ex_q [D];

  rmrt_pkg::in_word_t req_q;
  logic [CW-1:0] held_q, over_q, held_d, over_d;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] ix, ixm, ixp;
  logic [16:0] sum;
  logic [15:0] sat;
  rmrt_pkg::out_word_t out_q;
  logic strobe_q;

  assign ix  = idx_q[IW-1:0];
  assign ixm = IW'(idx_q - CW'(1));
  assign ixp = IW'(idx_q + CW'(1));
  assign sum = {1'b0, el_q[ix]} + {1'b0, req_q.elapsed_ms};
  assign sat = sum[16] ? 16'hFFFF : sum[15:0];

  // Status toward the controller.
  always_comb begin
    stat_o.command      = rmrt_pkg::cmd_e'(req_q.command);
    stat_o.full         = held_q >= CW'(D);
    stat_o.idx_at_end   = idx_q >= held_q;
    stat_o.id_match     = id_q[ix] == req_q.msg_id;
    stat_o.prev_greater = (idx_q != '0) && (id_q[ixm] > req_q.msg_id);
    stat_o.idx_last     = (idx_q + CW'(1)) >= held_q;
    stat_o.expire       = sat >= to_q[ix];
    stat_o.resend       = stat_o.expire && (rs_q[ix] < lim_q[ix]);
    stat_o.will_exceed  = stat_o.expire && !(rs_q[ix] < lim_q[ix]) && !ex_q[ix];
  end

  // Counts. The exceeded count is fixed while the leaving entry is still at idx.
  always_comb begin
    held_d = held_q;
    over_d = over_q;
    if (ctl_i.place) held_d = held_q + CW'(1);
    if (ctl_i.remove) held_d = held_q - CW'(1);
    if (ctl_i.drop_over && ex_q[ix] && over_q != '0) over_d = over_q - CW'(1);
    if (ctl_i.tick_step && stat_o.will_exceed) over_d = over_q + CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      over_q   <= '0;
      idx_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      held_q   <= held_d;
      over_q   <= over_d;
      strobe_q <= ctl_i.emit;
      if (ctl_i.load) idx_q <= '0;
      else if (ctl_i.set_idx_count) idx_q <= held_q;
      else if (ctl_i.idx_inc) idx_q <= idx_q + CW'(1);
      else if (ctl_i.idx_dec) idx_q <= idx_q - CW'(1);
    end
  end

  // Captured request and result register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) req_q <= in_i;
    if (ctl_i.emit) begin
      out_q.event_res      <= ctl_i.ev;
      out_q.msg_id_res     <= ctl_i.ev == rmrt_pkg::EvTickDone ? 32'd0 :
                              ctl_i.use_entry_id ? id_q[ix] : req_q.msg_id;
      out_q.entry_count    <= held_d;
      out_q.exceeded_count <= over_d;
      out_q.last           <= ctl_i.is_last;
    end
  end

  // Entry store updates, one slot per cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.shift_up) begin
      id_q[ix] <= id_q[ixm]; el_q[ix] <= el_q[ixm]; to_q[ix] <= to_q[ixm];
      lim_q[ix] <= lim_q[ixm]; rs_q[ix] <= rs_q[ixm]; ex_q[ix] <= ex_q[ixm];
    end else if (ctl_i.shift_down) begin
      id_q[ix] <= id_q[ixp]; el_q[ix] <= el_q[ixp]; to_q[ix] <= to_q[ixp];
      lim_q[ix] <= lim_q[ixp]; rs_q[ix] <= rs_q[ixp]; ex_q[ix] <= ex_q[ixp];
    end else if (ctl_i.place) begin
      id_q[ix] <= req_q.msg_id; el_q[ix] <= '0; to_q[ix] <= req_q.timeout_ms;
      lim_q[ix] <= req_q.max_resends; rs_q[ix] <= '0; ex_q[ix] <= 1'b0;
    end else if (ctl_i.tick_step) begin
      if (stat_o.resend) begin
        el_q[ix] <= '0;
        rs_q[ix] <= rs_q[ix] + 8'd1;
      end else begin
        el_q[ix] <= sat;
      end
      if (stat_o.will_exceed) ex_q[ix] <= 1'b1;
    end
  end

  assign out_o    = out_q;
  assign strobe_o = strobe_q;

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CW'(D)) else $error("held count beyond depth");
  a_over_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q <= held_q) else $error("exceeded count beyond held count");
  a_no_place_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.place |-> !stat_o.full) else $error("insert into full table");
endmodule
`default_nettype wire

// File: rtl/rmrt_ctrl.sv
// Controller state machine of the retransmission timer table.
`default_nettype none
module rmrt_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  output logic              load_o,
  input  wire rmrt_pkg::stat_t stat_i,
  output rmrt_pkg::ctl_t    ctl_o
);
  rmrt_pkg::state_e state_q, state_d;

  assign busy_o = state_q != rmrt_pkg::StIdle;
  assign load_o = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= rmrt_pkg::StIdle;
    else state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmrt_pkg::StIdle: if (load_o) state_d = rmrt_pkg::StSearch;
      rmrt_pkg::StSearch: begin
        unique case (stat_i.command)
          rmrt_pkg::CmdInsert: begin
            if (stat_i.full) state_d = rmrt_pkg::StDone;
            else if (stat_i.idx_at_end) state_d = rmrt_pkg::StShiftUp;
            else if (stat_i.id_match) state_d = rmrt_pkg::StDone;
          end
          rmrt_pkg::CmdAck: begin
            if (stat_i.idx_at_end) state_d = rmrt_pkg::StDone;
            else if (stat_i.id_match) state_d = rmrt_pkg::StShiftDown;
          end
          rmrt_pkg::CmdTick: state_d = rmrt_pkg::StTick;
          default: state_d = rmrt_pkg::StDone;
        endcase
      end
      rmrt_pkg::StShiftUp: if (!stat_i.prev_greater) state_d = rmrt_pkg::StDone;
      rmrt_pkg::StShiftDown: if (stat_i.idx_last) state_d = rmrt_pkg::StDone;
      rmrt_pkg::StTick: if (stat_i.idx_at_end) state_d = rmrt_pkg::StDone;
      rmrt_pkg::StDone: state_d = rmrt_pkg::StIdle;
      default: state_d = rmrt_pkg::StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl_o = '0;
    ctl_o.load = load_o;
    ctl_o.ev = rmrt_pkg::EvInserted;
    unique case (state_q)
      rmrt_pkg::StIdle: ;
      rmrt_pkg::StSearch: begin
        unique case (stat_i.command)
          rmrt_pkg::CmdInsert: begin
            if (stat_i.full) begin
              ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvFull; ctl_o.is_last = 1'b1;
            end else if (stat_i.idx_at_end) begin
              ctl_o.set_idx_count = 1'b1;
            end else if (stat_i.id_match) begin
              ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvDup; ctl_o.is_last = 1'b1;
            end else ctl_o.idx_inc = 1'b1;
          end
          rmrt_pkg::CmdAck: begin
            if (stat_i.idx_at_end) begin
              ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvNotFound;
              ctl_o.is_last = 1'b1;
            end else if (!stat_i.id_match) ctl_o.idx_inc = 1'b1;
            else ctl_o.drop_over = 1'b1;
          end
          default: ;
        endcase
      end
      rmrt_pkg::StShiftUp: begin
        if (stat_i.prev_greater) begin
          ctl_o.shift_up = 1'b1; ctl_o.idx_dec = 1'b1;
        end else begin
          ctl_o.place = 1'b1; ctl_o.emit = 1'b1;
          ctl_o.ev = rmrt_pkg::EvInserted; ctl_o.is_last = 1'b1;
        end
      end
      rmrt_pkg::StShiftDown: begin
        if (stat_i.idx_last) begin
          ctl_o.remove = 1'b1; ctl_o.emit = 1'b1;
          ctl_o.ev = rmrt_pkg::EvRemoved; ctl_o.is_last = 1'b1;
        end else begin
          ctl_o.shift_down = 1'b1; ctl_o.idx_inc = 1'b1;
        end
      end
      rmrt_pkg::StTick: begin
        if (stat_i.idx_at_end) begin
          ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvTickDone; ctl_o.is_last = 1'b1;
        end else begin
          ctl_o.tick_step = 1'b1; ctl_o.idx_inc = 1'b1;
          ctl_o.use_entry_id = 1'b1;
          if (stat_i.resend) begin
            ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvResend;
          end else if (stat_i.will_exceed) begin
            ctl_o.emit = 1'b1; ctl_o.ev = rmrt_pkg::EvExceeded;
          end
        end
      end
      rmrt_pkg::StDone: ;
      default: ;
    endcase
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_o |=> state_q == rmrt_pkg::StSearch) else $error("start not taken");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.emit && ctl_o.is_last) |=> !load_o) else $error("start during last");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.shift_up, ctl_o.shift_down, ctl_o.place, ctl_o.tick_step}))
    else $error("two store writes at once");
endmodule
`default_nettype wire

// File: rtl/reliable_message_retransmit_table.sv
// Top level of the retransmission timer table.
// An insert searches for a duplicate, then moves sorted slots up and places the new entry.
// A tick steps through the store one entry per cycle.
// An acknowledge searches for the id, then shifts the later entries down.
// Results appear in the cycle after their step, one per strobe; the receiver cannot stall.
// Reset clears the state machine and both counts; slot contents are not cleared.
`default_nettype none
module reliable_message_retransmit_table (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire rmrt_pkg::in_word_t   in_i,
  output logic                      strobe,
  output rmrt_pkg::out_word_t       out_o
);
  rmrt_pkg::ctl_t  ctl;
  rmrt_pkg::stat_t stat;
  logic load;

  rmrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .load_o(load),
    .stat_i(stat), .ctl_o(ctl)
  );

  rmrt_datapath u_dp (
    .clk_i, .rst_ni, .in_i, .ctl_i(ctl), .stat_o(stat), .out_o, .strobe_o(strobe)
  );

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load == (start && !busy)) else $error("load mismatch");
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |=> strobe) else $error("result lost");
  a_cmd_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_i.command == rmrt_pkg::CmdNone) |=> ##1 !strobe)
    else $error("result on unused code");
endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for the retransmission timer table: random and directed words against a predictor.
`timescale 1ns / 1ps

// Holds a copy of the table and the queue of expected result words.
class table_scoreboard;
  logic [31:0] ids[$];
  logic [15:0] elapsed[$];
  logic [15:0] intervals[$];
  logic [7:0]  limits[$];
  logic [7:0]  resends[$];
  bit          over[$];
  int unsigned over_total;
  rmrt_pkg::out_word_t pending[$];
  int unsigned errors;

  function new();
    over_total = 0;
    errors = 0;
  endfunction

  function void push_result(rmrt_pkg::event_e ev, logic [31:0] id);
    rmrt_pkg::out_word_t w;
    w.event_res = ev;
    w.msg_id_res = id;
    w.entry_count = 5'(ids.size());
    w.exceeded_count = 5'(over_total);
    w.last = 1'b0;
    pending = {pending, w};
  endfunction

  // Works out the result words for one accepted input word.
  function void note_input(rmrt_pkg::in_word_t w);
    int pos;
    int found;
    logic [16:0] t;
    int first_new;
    found = -1;
    first_new = pending.size();
    for (int i = 0; i < ids.size(); i++) if (ids[i] == w.msg_id) found = i;
    case (w.command)
      rmrt_pkg::CmdInsert: begin
        if (ids.size() >= rmrt_pkg::TableDepth) begin
          push_result(rmrt_pkg::EvFull, w.msg_id);
        end else if (found >= 0) begin
          push_result(rmrt_pkg::EvDup, w.msg_id);
        end else begin
          pos = ids.size();
          while (pos > 0 && ids[pos-1] > w.msg_id) pos--;
          ids.insert(pos, w.msg_id);
          elapsed.insert(pos, 16'd0);
          intervals.insert(pos, w.timeout_ms);
          limits.insert(pos, w.max_resends);
          resends.insert(pos, 8'd0);
          over.insert(pos, 1'b0);
          push_result(rmrt_pkg::EvInserted, w.msg_id);
        end
      end
      rmrt_pkg::CmdTick: begin
        for (int i = 0; i < ids.size(); i++) begin
          t = {1'b0, elapsed[i]} + {1'b0, w.elapsed_ms};
          if (t > 17'hFFFF) t = 17'hFFFF;
          elapsed[i] = t[15:0];
          if (elapsed[i] >= intervals[i]) begin
            if (resends[i] >= limits[i]) begin
              if (!over[i]) begin
                over[i] = 1'b1;
                over_total++;
                push_result(rmrt_pkg::EvExceeded, ids[i]);
              end
            end else begin
              resends[i]++;
              elapsed[i] = 16'd0;
              push_result(rmrt_pkg::EvResend, ids[i]);
            end
          end
        end
        push_result(rmrt_pkg::EvTickDone, 32'd0);
      end
      rmrt_pkg::CmdAck: begin
        if (found >= 0) begin
          if (over[found] && over_total > 0) over_total--;
          ids.delete(found);
          elapsed.delete(found);
          intervals.delete(found);
          limits.delete(found);
          resends.delete(found);
          over.delete(found);
          push_result(rmrt_pkg::EvRemoved, w.msg_id);
        end else begin
          push_result(rmrt_pkg::EvNotFound, w.msg_id);
        end
      end
      default: ;
    endcase
    if (pending.size() > first_new) pending[pending.size()-1].last = 1'b1;
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endfunction

  // Compares one result word with the oldest expectation.
  function void check_result(rmrt_pkg::out_word_t r);
    rmrt_pkg::out_word_t e;
    if (pending.size() == 0) begin
      report("unexpected word", r.msg_id_res, 32'd0);
      return;
    end
    e = pending.pop_front();
    if (r.event_res != e.event_res)
      report("event_res", 32'(r.event_res), 32'(e.event_res));
    if (r.msg_id_res != e.msg_id_res) report("msg_id_res", r.msg_id_res, e.msg_id_res);
    if (r.entry_count != e.entry_count)
      report("entry_count", 32'(r.entry_count), 32'(e.entry_count));
    if (r.exceeded_count != e.exceeded_count)
      report("exceeded_count", 32'(r.exceeded_count), 32'(e.exceeded_count));
    if (r.last != e.last) report("last", 32'(r.last), 32'(e.last));
  endfunction
endclass

module testbench;

  localparam int CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  rmrt_pkg::in_word_t in_i;
  logic strobe;
  rmrt_pkg::out_word_t out_o;

  table_scoreboard board;
  logic [31:0] id_pool[8];
  bit calm;
  int unsigned cycles;

  reliable_message_retransmit_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .strobe(strobe), .out_o(out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result words are sampled at the edge that ends their cycle.
  always @(posedge clk_i) begin
    if (rst_ni && strobe) board.check_result(out_o);
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one word and holds it until the block takes it; start stays high after
  // acceptance until the next word or the next idle stretch replaces it.
  task automatic send_word(rmrt_pkg::in_word_t w);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    board.note_input(w);
  endtask

  task automatic send_cmd(rmrt_pkg::cmd_e c, logic [31:0] id, logic [15:0] tmo,
                          logic [7:0] lim, logic [15:0] dt);
    rmrt_pkg::in_word_t w;
    w.command = c;
    w.msg_id = id;
    w.timeout_ms = tmo;
    w.max_resends = lim;
    w.elapsed_ms = dt;
    send_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (2 * rmrt_pkg::TableDepth + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_id();
    return ($urandom_range(4) == 0) ? $urandom() : id_pool[$urandom_range(7)];
  endfunction

  initial begin
    rmrt_pkg::in_word_t w;
    int unsigned r;
    board = new();
    cycles = 0;
    calm = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty tick, extremes, duplicates, zero interval, full table.
    send_cmd(rmrt_pkg::CmdTick, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 16'd0);
    send_cmd(rmrt_pkg::CmdAck, 32'd5, 16'd0, 8'd0, 16'd0);
    send_cmd(rmrt_pkg::CmdInsert, 32'hFFFFFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_cmd(rmrt_pkg::CmdInsert, 32'd0, 16'd0, 8'd0, 16'd0);
    send_cmd(rmrt_pkg::CmdInsert, 32'd0, 16'd3, 8'd1, 16'd0);
    send_cmd(rmrt_pkg::CmdInsert, 32'd100, 16'd10, 8'd1, 16'd0);
    send_cmd(rmrt_pkg::CmdTick, 32'd0, 16'd0, 8'd0, 16'd0);
    send_cmd(rmrt_pkg::CmdTick, 32'd0, 16'd0, 8'd0, 16'd0);
    send_cmd(rmrt_pkg::CmdTick, 32'd0, 16'd0, 8'd0, 16'hFFFF);
    send_cmd(rmrt_pkg::CmdTick, 32'd0, 16'd0, 8'd0, 16'hFFFF);
    send_cmd(rmrt_pkg::CmdNone, 32'hA5A5A5A5, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_cmd(rmrt_pkg::CmdAck, 32'd0, 16'd0, 8'd0, 16'd0);
    for (int i = 0; i < 16; i++)
      send_cmd(rmrt_pkg::CmdInsert, 32'd1000 - i * 7, 16'd50, 8'd2, 16'd0);
    send_cmd(rmrt_pkg::CmdInsert, 32'd7, 16'd1, 8'd1, 16'd0);
    send_cmd(rmrt_pkg::CmdAck, 32'hFFFFFFFF, 16'd0, 8'd0, 16'd0);
    drain();

    // Random phase; the pool keeps inserts and acks meeting the same ids.
    for (int i = 0; i < 8; i++) id_pool[i] = $urandom();
    id_pool[0] = 32'd0;
    id_pool[1] = 32'hFFFFFFFF;
    for (int n = 0; n < 130; n++) begin
      if (n == 65) drain();
      if (n == 105) calm = 1'b1;
      r = $urandom_range(99);
      w.command = (r < 45) ? rmrt_pkg::CmdInsert : (r < 70) ? rmrt_pkg::CmdTick :
                  (r < 97) ? rmrt_pkg::CmdAck : rmrt_pkg::CmdNone;
      w.msg_id = pick_id();
      w.timeout_ms = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(40));
      w.max_resends = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(3));
      w.elapsed_ms = ($urandom_range(5) == 0) ? 16'($urandom()) : 16'($urandom_range(30));
      send_word(w);
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: reliable_message_retransmit_table.f
rtl/rmrt_pkg.sv
rtl/rmrt_datapath.sv
rtl/rmrt_ctrl.sv
rtl/reliable_message_retransmit_table.sv
sim/testbench.sv
